/* rtl/bpsr_pkg.sv */
// package for the box projection screen rectangle block
// types, widths and constants shared by the front, back and top level
// no dependencies
package bpsr_pkg;

  localparam int COEF_COUNT  = 12;
  localparam int QUEUE_DEPTH = 2;
  localparam int SUM_W       = 56;
  localparam int NUM_W       = 58;
  localparam int MAG_W       = 46;
  localparam int QUO_W       = 38;
  localparam int RAT_W       = 39;
  localparam int SCR_W       = 56;
  localparam int W_MIN_Q24   = 167773;

  // register indexes on the configuration port
  localparam logic REG_SCREEN_WIDTH  = 1'b0;
  localparam logic REG_SCREEN_HEIGHT = 1'b1;

  // input op codes
  localparam logic OP_LOAD    = 1'b0;
  localparam logic OP_PROJECT = 1'b1;

  typedef enum logic [1:0] {
    KIND_LOAD,
    KIND_PROJECT,
    KIND_SKIP
  } kind_e;

  typedef struct packed {
    kind_e             kind;
    logic [3:0]        slot;
    logic [31:0]       value;
    logic [2:0][31:0]  lo;
    logic [2:0][31:0]  hi;
  } item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_START,
    ST_MUL,
    ST_CHECK,
    ST_NORM,
    ST_SAT,
    ST_DIV,
    ST_FIN,
    ST_SCALE,
    ST_OUT
  } state_e;

endpackage

/* rtl/box_projection_screen_rect_core.sv */
// box projection to a screen rectangle: the back writes a load beat in its idle state
// a project beat runs each of the eight corners through the multiply, the normalize
// shift of w (one bit a cycle) and the 38-step divider, then scales it
// an invalid corner ends the beat at once; one beat at a time in the back
// reset clears coefficients to zero, screen size to 1920 x 1080, the queue and the result valid flag
// depends on bpsr_pkg, bpsr_front and bpsr_back
module box_projection_screen_rect_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic                op_i,
  input  logic [3:0]          coef_index_i,
  input  logic signed [31:0]  coef_value_i,
  input  logic signed [31:0]  min_x_i,
  input  logic signed [31:0]  min_y_i,
  input  logic signed [31:0]  min_z_i,
  input  logic signed [31:0]  max_x_i,
  input  logic signed [31:0]  max_y_i,
  input  logic signed [31:0]  max_z_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic                rect_valid_o,
  output logic signed [15:0]  rect_left_o,
  output logic signed [15:0]  rect_low_y_o,
  output logic [15:0]         rect_width_o,
  output logic [15:0]         rect_height_o
);
  import bpsr_pkg::*;

  logic [13:0] screen_width_q, screen_height_q;
  logic        q_valid, q_pop;
  item_t       q_item;

  // configuration registers
  assign pready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      screen_width_q  <= 14'd1920;
      screen_height_q <= 14'd1080;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[2])
        REG_SCREEN_WIDTH:  screen_width_q  <= pwdata[13:0];
        REG_SCREEN_HEIGHT: screen_height_q <= pwdata[13:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_SCREEN_WIDTH:  prdata = {18'd0, screen_width_q};
      REG_SCREEN_HEIGHT: prdata = {18'd0, screen_height_q};
      default:           prdata = '0;
    endcase
  end

  bpsr_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .op_i, .coef_index_i, .coef_value_i,
    .min_x_i, .min_y_i, .min_z_i, .max_x_i, .max_y_i, .max_z_i,
    .q_valid_o (q_valid),
    .q_item_o  (q_item),
    .q_pop_i   (q_pop)
  );

  bpsr_back u_back (
    .clk_i, .rst_ni,
    .screen_width_i  (screen_width_q),
    .screen_height_i (screen_height_q),
    .q_valid_i       (q_valid),
    .q_item_i        (q_item),
    .q_pop_o         (q_pop),
    .out_valid_o, .out_stall_i, .rect_valid_o, .rect_left_o, .rect_low_y_o,
    .rect_width_o, .rect_height_o
  );

endmodule

/* rtl/bpsr_front.sv */
// front part: accepts beats, classifies them and queues them for the back
// depends on bpsr_pkg
module bpsr_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic                  op_i,
  input  logic [3:0]            coef_index_i,
  input  logic signed [31:0]    coef_value_i,
  input  logic signed [31:0]    min_x_i,
  input  logic signed [31:0]    min_y_i,
  input  logic signed [31:0]    min_z_i,
  input  logic signed [31:0]    max_x_i,
  input  logic signed [31:0]    max_y_i,
  input  logic signed [31:0]    max_z_i,
  output logic                  q_valid_o,
  output bpsr_pkg::item_t       q_item_o,
  input  logic                  q_pop_i
);
  import bpsr_pkg::*;

  item_t      entry_q [QUEUE_DEPTH];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;
  item_t      item_d;
  logic       push, pop;

  // classify the incoming beat
  always_comb begin
    item_d.slot  = coef_index_i;
    item_d.value = coef_value_i;
    item_d.lo    = {min_z_i, min_y_i, min_x_i};
    item_d.hi    = {max_z_i, max_y_i, max_x_i};
    if (op_i == OP_PROJECT) begin
      item_d.kind = KIND_PROJECT;
    end else if (32'(coef_index_i) < COEF_COUNT) begin
      item_d.kind = KIND_LOAD;
    end else begin
      item_d.kind = KIND_SKIP;
    end
  end

  assign in_stall_o = (count_q == 2'(QUEUE_DEPTH));
  assign push       = in_valid_i && !in_stall_o;
  assign q_valid_o  = (count_q != 2'd0);
  assign pop        = q_pop_i && q_valid_o;
  assign q_item_o   = entry_q[rd_ptr_q];

  // queue storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= item_d;
    end
  end

  // queue pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop)  rd_ptr_q <= ~rd_ptr_q;
      count_q <= count_q + 2'(push) - 2'(pop);
    end
  end

endmodule

/* rtl/bpsr_back.sv */
// back part: coefficient store, corner sequencer, shared multiplier,
// normalizer, dual divider, scaling and the result register
// depends on bpsr_pkg
module bpsr_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic [13:0]           screen_width_i,
  input  logic [13:0]           screen_height_i,
  input  logic                  q_valid_i,
  input  bpsr_pkg::item_t       q_item_i,
  output logic                  q_pop_o,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic                  rect_valid_o,
  output logic signed [15:0]    rect_left_o,
  output logic signed [15:0]    rect_low_y_o,
  output logic [15:0]           rect_width_o,
  output logic [15:0]           rect_height_o
);
  import bpsr_pkg::*;

  localparam logic signed [RAT_W-1:0] RatioSat = RAT_W'(64'd1 << 37);

  state_e state_q, state_d;

  logic signed [31:0]       coef_q [COEF_COUNT];
  logic [2:0][31:0]         lo_q, hi_q;
  logic [2:0]               corner_q;
  logic [1:0]               row_q, col_q;
  logic [5:0]               cnt_q;
  logic signed [SUM_W-1:0]  acc_q [3];
  logic [SUM_W-1:0]         wn_q;
  logic signed [NUM_W-1:0]  num_q [2];
  logic                     sat_q [2];
  logic                     neg_q [2];
  logic [23:0]              rem_q [2];
  logic [QUO_W-1:0]         dd_q [2];
  logic [QUO_W-1:0]         quo_q [2];
  logic signed [RAT_W-1:0]  ratio_q [2];
  logic signed [SCR_W-1:0]  minx_q, maxx_q, miny_q, maxy_q;
  logic                     ok_q;
  logic                     out_valid_q;
  logic                     res_valid_q;
  logic signed [15:0]       res_left_q, res_low_q;
  logic [15:0]              res_w_q, res_h_q;

  // shared multiply-accumulate for one coefficient times one coordinate
  logic [3:0]               slot;
  logic signed [31:0]       p_sel;
  logic signed [63:0]       prod;
  logic signed [SUM_W-1:0]  prod_fl;

  assign slot    = {row_q, col_q};
  assign p_sel   = corner_q[col_q] ? $signed(hi_q[col_q]) : $signed(lo_q[col_q]);
  assign prod    = coef_q[slot] * p_sel;
  assign prod_fl = SUM_W'(prod >>> 12);

  // saturation bound and magnitude of each normalized numerator
  logic signed [NUM_W-1:0]  lim;
  logic signed [NUM_W-1:0]  mag_full [2];
  assign lim = $signed({13'd0, wn_q[23:0], 21'd0});

  // one restoring step of each divider
  logic [24:0] r2 [2];
  logic        ge [2];

  // scaling products
  logic signed [53:0]       sprod [2];
  logic signed [SCR_W-1:0]  sx, sy;

  always_comb begin
    for (int a = 0; a < 2; a++) begin
      mag_full[a] = num_q[a][NUM_W-1] ? -num_q[a] : num_q[a];
      r2[a]       = {rem_q[a], dd_q[a][QUO_W-1]};
      ge[a]       = r2[a] >= {1'b0, wn_q[23:0]};
    end
    sprod[0] = $signed({1'b0, screen_width_i}) * ratio_q[0];
    sprod[1] = $signed({1'b0, screen_height_i}) * ratio_q[1];
    sx = SCR_W'(sprod[0] >>> 9) + SCR_W'(128);
    sy = SCR_W'(sprod[1] >>> 9) - SCR_W'(128);
  end

  // final rectangle from the extremes
  logic signed [SCR_W-1:0] tl, ty, dx, dy;
  logic signed [15:0]      left_s, low_s;
  logic [15:0]             w_s, h_s;

  function automatic logic signed [SCR_W-1:0] trunc_q8(logic signed [SCR_W-1:0] v);
    logic signed [SCR_W-1:0] m;
    m = -v;
    return v[SCR_W-1] ? -(m >>> 8) : (v >>> 8);
  endfunction

  function automatic logic signed [15:0] sat_s16(logic signed [SCR_W-1:0] v);
    if (v > SCR_W'(32767)) return 16'sd32767;
    if (v < -SCR_W'(32768)) return -16'sd32768;
    return v[15:0];
  endfunction

  function automatic logic [15:0] sat_u16(logic signed [SCR_W-1:0] v);
    if (v > SCR_W'(65535)) return 16'hFFFF;
    if (v[SCR_W-1]) return 16'd0;
    return v[15:0];
  endfunction

  always_comb begin
    tl     = trunc_q8(minx_q);
    ty     = trunc_q8(miny_q);
    dx     = trunc_q8(maxx_q - minx_q);
    dy     = trunc_q8(maxy_q - miny_q);
    left_s = ok_q ? sat_s16(tl) : 16'sd0;
    low_s  = ok_q ? sat_s16(ty) : 16'sd0;
    w_s    = ok_q ? sat_u16(dx) : 16'd0;
    h_s    = ok_q ? sat_u16(dy) : 16'd0;
  end

  logic out_free;
  assign out_free = !out_valid_q || !out_stall_i;

  // next state
  always_comb begin
    state_d = state_q;
    q_pop_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          if (q_item_i.kind == KIND_PROJECT) state_d = ST_START;
        end
      end
      ST_START: state_d = ST_MUL;
      ST_MUL: begin
        if (row_q == 2'd2 && col_q == 2'd2) state_d = ST_CHECK;
      end
      ST_CHECK: begin
        if (acc_q[2] < SUM_W'(W_MIN_Q24)) state_d = ST_OUT;
        else state_d = ST_NORM;
      end
      ST_NORM: begin
        if (wn_q[SUM_W-1:24] == '0) state_d = ST_SAT;
      end
      ST_SAT: state_d = ST_DIV;
      ST_DIV: begin
        if (cnt_q == 6'(QUO_W - 1)) state_d = ST_FIN;
      end
      ST_FIN: state_d = ST_SCALE;
      ST_SCALE: begin
        if (corner_q == 3'd7) state_d = ST_OUT;
        else state_d = ST_START;
      end
      ST_OUT: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // coefficient store
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < COEF_COUNT; i++) coef_q[i] <= '0;
    end else if (state_q == ST_IDLE && q_valid_i && q_item_i.kind == KIND_LOAD) begin
      coef_q[q_item_i.slot] <= q_item_i.value;
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        lo_q     <= q_item_i.lo;
        hi_q     <= q_item_i.hi;
        corner_q <= 3'd0;
        ok_q     <= 1'b1;
      end
      ST_START: begin
        acc_q[0] <= SUM_W'(coef_q[3]);
        acc_q[1] <= SUM_W'(coef_q[7]);
        acc_q[2] <= SUM_W'(coef_q[11]);
        row_q    <= 2'd0;
        col_q    <= 2'd0;
      end
      ST_MUL: begin
        acc_q[row_q] <= acc_q[row_q] + prod_fl;
        if (col_q == 2'd2) begin
          col_q <= 2'd0;
          row_q <= row_q + 2'd1;
        end else begin
          col_q <= col_q + 2'd1;
        end
      end
      ST_CHECK: begin
        if (acc_q[2] < SUM_W'(W_MIN_Q24)) ok_q <= 1'b0;
        wn_q     <= acc_q[2];
        num_q[0] <= NUM_W'(acc_q[2]) + NUM_W'(acc_q[0]);
        num_q[1] <= NUM_W'(acc_q[2]) - NUM_W'(acc_q[1]);
      end
      ST_NORM: begin
        if (wn_q[SUM_W-1:24] != '0) begin
          wn_q     <= wn_q >> 1;
          num_q[0] <= num_q[0] >>> 1;
          num_q[1] <= num_q[1] >>> 1;
        end
      end
      ST_SAT: begin
        cnt_q <= 6'd0;
        for (int a = 0; a < 2; a++) begin
          sat_q[a] <= (num_q[a] >= lim) || (num_q[a] <= -lim);
          neg_q[a] <= num_q[a][NUM_W-1];
          rem_q[a] <= mag_full[a][MAG_W-1:22];
          dd_q[a]  <= {mag_full[a][21:0], 16'd0};
          quo_q[a] <= '0;
        end
      end
      ST_DIV: begin
        cnt_q <= cnt_q + 6'd1;
        for (int a = 0; a < 2; a++) begin
          dd_q[a]  <= dd_q[a] << 1;
          quo_q[a] <= {quo_q[a][QUO_W-2:0], ge[a]};
          rem_q[a] <= ge[a] ? 24'(r2[a] - {1'b0, wn_q[23:0]}) : r2[a][23:0];
        end
      end
      ST_FIN: begin
        for (int a = 0; a < 2; a++) begin
          if (sat_q[a]) begin
            ratio_q[a] <= neg_q[a] ? -RatioSat : RatioSat;
          end else if (neg_q[a]) begin
            ratio_q[a] <= -$signed({1'b0, quo_q[a]}) - RAT_W'(rem_q[a] != '0);
          end else begin
            ratio_q[a] <= $signed({1'b0, quo_q[a]});
          end
        end
      end
      ST_SCALE: begin
        corner_q <= corner_q + 3'd1;
        if (corner_q == 3'd0 || sx < minx_q) minx_q <= sx;
        if (corner_q == 3'd0 || sx > maxx_q) maxx_q <= sx;
        if (corner_q == 3'd0 || sy < miny_q) miny_q <= sy;
        if (corner_q == 3'd0 || sy > maxy_q) maxy_q <= sy;
      end
      default: ;
    endcase
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == ST_OUT && out_free) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_OUT && out_free) begin
      res_valid_q <= ok_q;
      res_left_q  <= left_s;
      res_low_q   <= low_s;
      res_w_q     <= w_s;
      res_h_q     <= h_s;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign rect_valid_o  = res_valid_q;
  assign rect_left_o   = res_left_q;
  assign rect_low_y_o  = res_low_q;
  assign rect_width_o  = res_w_q;
  assign rect_height_o = res_h_q;

endmodule

/* rtl/bpsr_checker.sv */
// port-level checks for the box projection screen rectangle block
// depends on box_projection_screen_rect_core, attached by bind
module bpsr_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         out_valid_o,
  input logic         out_stall_i,
  input logic         rect_valid_o,
  input logic [15:0]  rect_left_o,
  input logic [15:0]  rect_low_y_o,
  input logic [15:0]  rect_width_o,
  input logic [15:0]  rect_height_o,
  input logic         pready
);

  // stalled result beat stays valid and keeps its left and width fields
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(rect_left_o)
      && $stable(rect_width_o))
    else $error("result beat changed under stall");

  // invalid rectangle carries zero fields
  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !rect_valid_o |-> rect_left_o == 16'd0 && rect_low_y_o == 16'd0
      && rect_width_o == 16'd0 && rect_height_o == 16'd0)
    else $error("invalid rectangle with nonzero fields");

  // no result straight out of reset
  a_reset_empty: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !out_valid_o)
    else $error("result beat present after reset");

  // config port never waits
  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni) pready)
    else $error("pready low");

endmodule

bind box_projection_screen_rect_core bpsr_checker u_bpsr_checker (
  .clk_i, .rst_ni, .out_valid_o, .out_stall_i, .rect_valid_o,
  .rect_left_o (rect_left_o), .rect_low_y_o (rect_low_y_o),
  .rect_width_o, .rect_height_o, .pready
);

/* tb/sv/tb.sv */
// testbench for box_projection_screen_rect_core: coefficient loads and box projections
// drives beats from a queue, predicts each screen rectangle and checks it on the output
// depends on bpsr_pkg and the rtl of the block
`timescale 1ns / 1ps

module tb;
  import bpsr_pkg::*;

  typedef struct {
    logic        op;
    logic [3:0]  idx;
    logic [31:0] val;
    logic [31:0] lo [3];
    logic [31:0] hi [3];
  } beat_t;

  typedef struct {
    logic        ok;
    logic [15:0] left;
    logic [15:0] low_y;
    logic [15:0] wid;
    logic [15:0] hgt;
  } rect_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic op_i = 1'b0;
  logic [3:0] coef_index_i = '0;
  logic signed [31:0] coef_value_i = '0;
  logic signed [31:0] min_x_i = '0, min_y_i = '0, min_z_i = '0;
  logic signed [31:0] max_x_i = '0, max_y_i = '0, max_z_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic rect_valid_o;
  logic signed [15:0] rect_left_o, rect_low_y_o;
  logic [15:0] rect_width_o, rect_height_o;

  box_projection_screen_rect_core dut (.*);

  always #2 clk_i = ~clk_i;

  beat_t pending_beats[$];
  rect_t expected_rects[$];
  logic [31:0] view_coef[COEF_COUNT];
  logic [13:0] scr_w, scr_h;
  int errors = 0;
  int rects_seen = 0;
  int invalid_seen = 0;
  int burst_left = 0;
  int gap_left = 0;
  int stall_phase = 0;
  bit stall_quiet = 0;

  function automatic longint floor_shift(longint v, int k);
    return v >>> k;
  endfunction

  function automatic longint floor_div(longint a, longint b);
    longint q;
    q = a / b;
    if (a % b != 0 && a < 0) q--;
    return q;
  endfunction

  // ratio num/w in Q.16 with w normalized below 2^24 and a saturating far-off ratio
  function automatic longint ratio_q16(longint num, longint w);
    int s;
    longint wn, nn;
    s = 0;
    while ((w >>> s) >= (64'sd1 <<< 24)) s++;
    wn = w >>> s;
    nn = num >>> s;
    if (nn >= wn * (64'sd1 <<< 21)) return 64'sd1 <<< 37;
    if (nn <= -wn * (64'sd1 <<< 21)) return -(64'sd1 <<< 37);
    return floor_div(nn * 65536, wn);
  endfunction

  function automatic longint row_dot(int row, longint p[3]);
    longint s;
    s = longint'($signed(view_coef[row * 4 + 3]));
    for (int c = 0; c < 3; c++)
      s += floor_shift(longint'($signed(view_coef[row * 4 + c])) * p[c], 12);
    return s;
  endfunction

  function automatic longint toward_zero_q8(longint v);
    return v >= 0 ? (v >>> 8) : -((-v) >>> 8);
  endfunction

  function automatic logic [15:0] clamp_s16(longint v);
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v[15:0];
  endfunction

  function automatic logic [15:0] clamp_u16(longint v);
    if (v > 65535) v = 65535;
    if (v < 0) v = 0;
    return v[15:0];
  endfunction

  // screen rectangle of the eight projected corners, or an invalid rectangle
  function automatic rect_t project_box(beat_t b);
    rect_t r;
    longint p[3], x, y, w, sx, sy, mnx, mxx, mny, mxy;
    r = '{1'b0, '0, '0, '0, '0};
    mnx = 0; mxx = 0; mny = 0; mxy = 0;
    for (int k = 0; k < 8; k++) begin
      for (int a = 0; a < 3; a++)
        p[a] = longint'($signed(((k >> a) & 1) ? b.hi[a] : b.lo[a]));
      x = row_dot(0, p);
      y = row_dot(1, p);
      w = row_dot(2, p);
      if (w < W_MIN_Q24) return r;
      sx = floor_shift(longint'(scr_w) * ratio_q16(w + x, w), 9) + 128;
      sy = floor_shift(longint'(scr_h) * ratio_q16(w - y, w), 9) - 128;
      if (k == 0 || sx < mnx) mnx = sx;
      if (k == 0 || sx > mxx) mxx = sx;
      if (k == 0 || sy < mny) mny = sy;
      if (k == 0 || sy > mxy) mxy = sy;
    end
    r.ok = 1'b1;
    r.left = clamp_s16(toward_zero_q8(mnx));
    r.low_y = clamp_s16(toward_zero_q8(mny));
    r.wid = clamp_u16(toward_zero_q8(mxx - mnx));
    r.hgt = clamp_u16(toward_zero_q8(mxy - mny));
    return r;
  endfunction

  // sender: bursts and gaps, payload held while stalled
  always @(posedge clk_i) begin
    beat_t b;
    if (in_valid_i && !in_stall_o) begin
      b = pending_beats.pop_front();
      if (b.op == OP_PROJECT) expected_rects.push_back(project_box(b));
      else if (b.idx < COEF_COUNT) view_coef[b.idx] = b.val;
    end
    if (!(in_valid_i && in_stall_o)) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid_i <= 1'b0;
      end else if (pending_beats.size() > 0 && rst_ni) begin
        b = pending_beats[0];
        in_valid_i <= 1'b1;
        op_i <= b.op;
        coef_index_i <= b.idx;
        coef_value_i <= b.val;
        min_x_i <= b.lo[0]; min_y_i <= b.lo[1]; min_z_i <= b.lo[2];
        max_x_i <= b.hi[0]; max_y_i <= b.hi[1]; max_z_i <= b.hi[2];
        if (burst_left > 0) burst_left--;
        else begin
          burst_left = $urandom_range(0, 6);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 5);
        end
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // receiver stall pattern and result checks
  always @(posedge clk_i) begin
    rect_t e;
    if (out_valid_o && !out_stall_i) begin
      if (expected_rects.size() == 0) begin
        $display("%0t: rect with none expected: valid=%0b left=%0d", $time,
                 rect_valid_o, rect_left_o);
        errors++;
      end else begin
        e = expected_rects.pop_front();
        rects_seen++;
        if (!e.ok) invalid_seen++;
        if (rect_valid_o !== e.ok || rect_left_o !== e.left ||
            rect_low_y_o !== e.low_y || rect_width_o !== e.wid ||
            rect_height_o !== e.hgt) begin
          $display("%0t: expected v=%0b l=%0d y=%0d w=%0d h=%0d", $time, e.ok,
                   $signed(e.left), $signed(e.low_y), e.wid, e.hgt);
          $display("%0t: actual   v=%0b l=%0d y=%0d w=%0d h=%0d", $time,
                   rect_valid_o, rect_left_o, rect_low_y_o, rect_width_o,
                   rect_height_o);
          errors++;
        end
      end
    end
    stall_phase++;
    if (stall_phase % 200 == 0) stall_quiet = ($urandom_range(0, 3) == 0);
    out_stall_i <= stall_quiet ? 1'b0 : ((stall_phase % 7) < 3 ||
                                         $urandom_range(0, 4) == 0);
  end

  task automatic write_reg(logic idx, logic [31:0] v);
    @(posedge clk_i);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
    paddr <= {idx, 2'b00}; pwdata <= v;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (idx == REG_SCREEN_WIDTH) scr_w = v[13:0];
    else scr_h = v[13:0];
  endtask

  task automatic drain;
    while (pending_beats.size() > 0 || in_valid_i || expected_rects.size() > 0)
      @(posedge clk_i);
    repeat (800) @(posedge clk_i);
  endtask

  task automatic add_load(logic [3:0] idx, logic [31:0] v);
    beat_t b;
    b.op = OP_LOAD; b.idx = idx; b.val = v;
    for (int a = 0; a < 3; a++) begin
      b.lo[a] = $urandom; b.hi[a] = $urandom;
    end
    pending_beats.push_back(b);
  endtask

  task automatic add_box(logic [31:0] l0, l1, l2, h0, h1, h2);
    beat_t b;
    b.op = OP_PROJECT; b.idx = 4'($urandom); b.val = $urandom;
    b.lo = '{l0, l1, l2}; b.hi = '{h0, h1, h2};
    pending_beats.push_back(b);
  endtask

  // coordinate, mostly modest so the box lands in front, sometimes any value
  function automatic logic [31:0] rand_coord(bit wild);
    if (wild) return $urandom;
    return $signed($urandom_range(0, 80000)) - 40000;
  endfunction

  // a camera-like matrix: w driven by z with a forward offset
  task automatic add_camera(bit wild);
    for (int i = 0; i < 12; i++) begin
      logic [31:0] v;
      if (wild) v = $urandom;
      else if (i == 10) v = 32'h0100_0000 + $urandom_range(0, 32'h00ff_ffff);
      else if (i == 11) v = 32'h0400_0000 + $urandom_range(0, 32'h0fff_ffff);
      else if (i == 0 || i == 5) v = 32'h0100_0000 + $urandom_range(0, 32'h007f_ffff);
      else v = $signed($urandom_range(0, 32'h0080_0000)) - 32'sh0040_0000;
      add_load(i[3:0], v);
    end
  endtask

  task automatic add_random_box(bit wild);
    logic [31:0] a0, a1, a2;
    a0 = rand_coord(wild); a1 = rand_coord(wild); a2 = rand_coord(wild);
    add_box(a0, a1, a2, wild ? $urandom : a0 + $urandom_range(0, 20000),
            wild ? $urandom : a1 + $urandom_range(0, 20000),
            wild ? $urandom : a2 + $urandom_range(0, 20000));
  endtask

  initial begin
    int phase_sizes[5];
    logic [13:0] widths[5], heights[5];
    for (int i = 0; i < COEF_COUNT; i++) view_coef[i] = '0;
    scr_w = 14'd1920; scr_h = 14'd1080;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: zero matrix gives an invalid corner, then a camera and extremes
    add_box('0, '0, '0, '0, '0, '0);
    add_load(4'd10, 32'h0100_0000);
    add_load(4'd11, 32'h0400_0000);
    add_load(4'd0, 32'h0100_0000);
    add_load(4'd5, 32'h0100_0000);
    add_box(32'hffff_f000, 32'hffff_f000, 32'h0000_1000,
            32'h0000_1000, 32'h0000_1000, 32'h0000_2000);
    add_load(4'd12, 32'hdead_beef);
    add_load(4'd15, 32'hffff_ffff);
    add_box(32'h8000_0000, 32'h8000_0000, 32'h0, 32'h7fff_ffff, 32'h7fff_ffff, 32'h0);
    add_load(4'd11, 32'h0000_2900);
    add_box(32'h0010_0000, 32'hfff0_0000, 32'h0, 32'h0010_0000, 32'hfff0_0000, 32'h0);
    add_load(4'd11, 32'h0000_28f6);
    add_box('0, '0, '0, '0, '0, '0);
    add_load(4'd11, 32'h7fff_ffff);
    add_load(4'd10, 32'h8000_0000);
    add_box(32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000,
            32'h7fff_ffff, 32'h8000_0000, 32'h0000_0fff);
    add_load(4'd1, 32'h7fff_ffff);
    add_box(32'h0, 32'h0, 32'hffff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h0);
    drain();

    widths = '{14'd1, 14'd8192, 14'd0, 14'd16383, 14'd640};
    heights = '{14'd8192, 14'd1, 14'd16383, 14'd0, 14'd480};
    phase_sizes = '{48, 48, 24, 24, 96};
    for (int ph = 0; ph < 5; ph++) begin
      write_reg(REG_SCREEN_WIDTH, {18'h3ffff, widths[ph]});
      write_reg(REG_SCREEN_HEIGHT, {18'($urandom_range(0, 32'h3ffff)), heights[ph]});
      for (int n = 0; n < phase_sizes[ph]; n++) begin
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 6) add_camera(pick < 1);
        else if (pick < 12) add_load(4'($urandom), $urandom);
        else add_random_box(pick < 25);
      end
      drain();
    end

    $display("covered %0d rectangles, %0d of them invalid, over six screen settings",
             rects_seen, invalid_seen);
    if (errors == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

  initial begin
    #40ms;
    $display("status: fail");
    $finish;
  end
endmodule

/* files.f */
rtl/bpsr_pkg.sv
rtl/bpsr_front.sv
rtl/bpsr_back.sv
rtl/box_projection_screen_rect_core.sv
rtl/bpsr_checker.sv
tb/sv/tb.sv
